// File: rtl/qes_pkg.sv
package qes_pkg;

  // Q16 of one minus and one plus the Gauss abscissa 1/sqrt(3)
  localparam logic [16:0] FAC_LO = 17'd27699;
  localparam logic [16:0] FAC_HI = 17'd103373;

  localparam int unsigned LANES     = 8;
  localparam int unsigned DIV_STEPS = 128;

  typedef enum logic [1:0] {
    CFG_D_DIAG    = 2'd0,
    CFG_D_OFFDIAG = 2'd1,
    CFG_D_SHEAR   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]         point;
    logic signed [31:0] x_node0;
    logic signed [31:0] x_node1;
    logic signed [31:0] x_node2;
    logic signed [31:0] x_node3;
    logic signed [31:0] y_node0;
    logic signed [31:0] y_node1;
    logic signed [31:0] y_node2;
    logic signed [31:0] y_node3;
  } in_t;

  typedef struct packed {
    logic signed [63:0] k_col0;
    logic signed [63:0] k_col1;
    logic signed [63:0] k_col2;
    logic signed [63:0] k_col3;
    logic signed [63:0] k_col4;
    logic signed [63:0] k_col5;
    logic signed [63:0] k_col6;
    logic signed [63:0] k_col7;
    logic signed [31:0] x_at_point;
    logic signed [31:0] y_at_point;
    logic               singular;
    logic               last;
  } out_t;

  // per-row facts that ride along the datapath
  typedef struct packed {
    logic [63:0] jm;
    logic        jneg;
    logic        sing;
    logic [31:0] xl;
    logic [31:0] yl;
    logic        last;
  } side_t;

  typedef struct packed {
    logic [3:0][33:0] u;
    logic [3:0][33:0] v;
    logic [2:0]       row;
    side_t            side;
  } geo_t;

endpackage

// File: rtl/qes_geom.sv
module qes_geom (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  qes_pkg::in_t   item_i,
  input  logic [2:0]     row_i,
  output logic           valid_o,
  output qes_pkg::geo_t  geo_o
);

  // stage a: node products
  logic [16:0]        sm, sp, tm, tp;
  logic [16:0]        nsm [4];
  logic [16:0]        ntm [4];
  logic [33:0]        n4 [4];
  logic signed [31:0] xc [4];
  logic signed [31:0] yc [4];

  assign sm = item_i.point[1] ? qes_pkg::FAC_LO : qes_pkg::FAC_HI;
  assign sp = item_i.point[1] ? qes_pkg::FAC_HI : qes_pkg::FAC_LO;
  assign tm = item_i.point[0] ? qes_pkg::FAC_LO : qes_pkg::FAC_HI;
  assign tp = item_i.point[0] ? qes_pkg::FAC_HI : qes_pkg::FAC_LO;

  assign nsm[0] = tm;
  assign nsm[1] = tp;
  assign nsm[2] = tp;
  assign nsm[3] = tm;
  assign ntm[0] = sm;
  assign ntm[1] = sm;
  assign ntm[2] = sp;
  assign ntm[3] = sp;
  assign n4[0]  = sm * tm;
  assign n4[1]  = sm * tp;
  assign n4[2]  = sp * tp;
  assign n4[3]  = sp * tm;

  assign xc[0] = item_i.x_node0;
  assign xc[1] = item_i.x_node1;
  assign xc[2] = item_i.x_node2;
  assign xc[3] = item_i.x_node3;
  assign yc[0] = item_i.y_node0;
  assign yc[1] = item_i.y_node1;
  assign yc[2] = item_i.y_node2;
  assign yc[3] = item_i.y_node3;

  logic signed [49:0] pxs_q [4];
  logic signed [49:0] pxt_q [4];
  logic signed [49:0] pys_q [4];
  logic signed [49:0] pyt_q [4];
  logic signed [66:0] plx_q [4];
  logic signed [66:0] ply_q [4];
  logic [1:0]         a_point_q;
  logic [2:0]         a_row_q;
  logic               a_valid_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) begin
        pxs_q[i] <= $signed({1'b0, nsm[i]}) * xc[i];
        pxt_q[i] <= $signed({1'b0, ntm[i]}) * xc[i];
        pys_q[i] <= $signed({1'b0, nsm[i]}) * yc[i];
        pyt_q[i] <= $signed({1'b0, ntm[i]}) * yc[i];
        plx_q[i] <= $signed({1'b0, n4[i]}) * xc[i];
        ply_q[i] <= $signed({1'b0, n4[i]}) * yc[i];
      end
      a_point_q <= item_i.point;
      a_row_q   <= row_i;
    end
  end

  // stage b: derivative sums, rounding, location
  logic signed [51:0] xs_r, xt_r, ys_r, yt_r;
  logic signed [68:0] lx_r, ly_r;

  assign xs_r = pxs_q[2] + pxs_q[3] - pxs_q[0] - pxs_q[1] + 52'sd131072;
  assign xt_r = pxt_q[1] + pxt_q[2] - pxt_q[0] - pxt_q[3] + 52'sd131072;
  assign ys_r = pys_q[2] + pys_q[3] - pys_q[0] - pys_q[1] + 52'sd131072;
  assign yt_r = pyt_q[1] + pyt_q[2] - pyt_q[0] - pyt_q[3] + 52'sd131072;
  assign lx_r = plx_q[0] + plx_q[1] + plx_q[2] + plx_q[3] + 69'sd8589934592;
  assign ly_r = ply_q[0] + ply_q[1] + ply_q[2] + ply_q[3] + 69'sd8589934592;

  logic signed [32:0] xs_q, xt_q, ys_q, yt_q;
  logic [31:0]        b_xl_q, b_yl_q;
  logic [1:0]         b_point_q;
  logic [2:0]         b_row_q;
  logic               b_valid_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xs_q      <= xs_r[50:18];
      xt_q      <= xt_r[50:18];
      ys_q      <= ys_r[50:18];
      yt_q      <= yt_r[50:18];
      b_xl_q    <= lx_r[65:34];
      b_yl_q    <= ly_r[65:34];
      b_point_q <= a_point_q;
      b_row_q   <= a_row_q;
    end
  end

  // stage c: jacobian and inverse-term products
  logic [16:0] smb, spb, tmb, tpb;

  assign smb = b_point_q[1] ? qes_pkg::FAC_LO : qes_pkg::FAC_HI;
  assign spb = b_point_q[1] ? qes_pkg::FAC_HI : qes_pkg::FAC_LO;
  assign tmb = b_point_q[0] ? qes_pkg::FAC_LO : qes_pkg::FAC_HI;
  assign tpb = b_point_q[0] ? qes_pkg::FAC_HI : qes_pkg::FAC_LO;

  logic signed [50:0] yt_tm_q, yt_tp_q, ys_sm_q, ys_sp_q;
  logic signed [50:0] xs_sm_q, xs_sp_q, xt_tm_q, xt_tp_q;
  logic signed [65:0] jp1_q, jp2_q;
  logic [31:0]        c_xl_q, c_yl_q;
  logic [2:0]         c_row_q;
  logic               c_valid_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      yt_tm_q <= yt_q * $signed({1'b0, tmb});
      yt_tp_q <= yt_q * $signed({1'b0, tpb});
      ys_sm_q <= ys_q * $signed({1'b0, smb});
      ys_sp_q <= ys_q * $signed({1'b0, spb});
      xs_sm_q <= xs_q * $signed({1'b0, smb});
      xs_sp_q <= xs_q * $signed({1'b0, spb});
      xt_tm_q <= xt_q * $signed({1'b0, tmb});
      xt_tp_q <= xt_q * $signed({1'b0, tpb});
      jp1_q   <= xs_q * yt_q;
      jp2_q   <= xt_q * ys_q;
      c_xl_q  <= b_xl_q;
      c_yl_q  <= b_yl_q;
      c_row_q <= b_row_q;
    end
  end

  // stage d: strain terms, determinant
  logic signed [51:0] ur [4];
  logic signed [51:0] vr [4];
  logic signed [66:0] jdet;
  logic [66:0]        jabs;
  qes_pkg::geo_t      geo_d;
  qes_pkg::geo_t      geo_q;
  logic               d_valid_q;

  assign ur[0] = ys_sm_q - yt_tm_q + 52'sd131072;
  assign ur[1] = 52'sd131072 - yt_tp_q - ys_sm_q;
  assign ur[2] = yt_tp_q - ys_sp_q + 52'sd131072;
  assign ur[3] = yt_tm_q + ys_sp_q + 52'sd131072;
  assign vr[0] = xt_tm_q - xs_sm_q + 52'sd131072;
  assign vr[1] = xs_sm_q + xt_tp_q + 52'sd131072;
  assign vr[2] = xs_sp_q - xt_tp_q + 52'sd131072;
  assign vr[3] = 52'sd131072 - xs_sp_q - xt_tm_q;
  assign jdet  = jp1_q - jp2_q;
  assign jabs  = jdet[66] ? -jdet : jdet;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      geo_d.u[i] = ur[i][51:18];
      geo_d.v[i] = vr[i][51:18];
    end
    geo_d.row       = c_row_q;
    geo_d.side.jm   = jabs[63:0];
    geo_d.side.jneg = jdet[66];
    geo_d.side.sing = (jdet == '0);
    geo_d.side.xl   = c_xl_q;
    geo_d.side.yl   = c_yl_q;
    geo_d.side.last = (c_row_q == 3'd7);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      geo_q <= geo_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
      d_valid_q <= c_valid_q;
    end
  end

  assign valid_o = d_valid_q;
  assign geo_o   = geo_q;

endmodule

// File: rtl/qes_numer.sv
module qes_numer (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  qes_pkg::geo_t           geo_i,
  input  logic [47:0]             d_diag_i,
  input  logic [47:0]             d_offdiag_i,
  input  logic [47:0]             d_shear_i,
  output logic                    valid_o,
  output logic [7:0][127:0]       dividend_o,
  output logic [7:0]              nneg_o,
  output qes_pkg::side_t          side_o
);

  localparam int unsigned NSTG = 5;

  qes_pkg::side_t side_q [NSTG];
  logic           vld_q [NSTG];

  logic [1:0]         node;
  logic               rsel;
  logic signed [33:0] ui, vi;

  assign node = geo_i.row[2:1];
  assign rsel = geo_i.row[0];
  assign ui   = $signed(geo_i.u[node]);
  assign vi   = $signed(geo_i.v[node]);

  // stage e: strain products, wrapped to 64 bits
  logic signed [63:0] p_q [8][2];
  logic               diag_q [8];

  for (genvar n = 0; n < 8; n++) begin : g_col
    localparam int unsigned JN = n / 2;
    localparam logic        CN = 1'(n % 2);
    logic signed [33:0] a1, b1, a2, b2;
    logic signed [67:0] m1, m2;

    assign a1 = rsel ? vi : ui;
    assign a2 = rsel ? ui : vi;
    assign b1 = CN ? $signed(geo_i.v[JN]) : $signed(geo_i.u[JN]);
    assign b2 = CN ? $signed(geo_i.u[JN]) : $signed(geo_i.v[JN]);
    assign m1 = a1 * b1;
    assign m2 = a2 * b2;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        p_q[n][0] <= m1[63:0];
        p_q[n][1] <= m2[63:0];
        diag_q[n] <= (rsel == CN);
      end
    end
  end

  // stage f: partial products against the material terms
  logic [63:0]        pp0_q [8][2];
  logic [47:0]        pp1_q [8][2];
  logic signed [64:0] pp2_q [8][2];
  logic signed [48:0] pp3_q [8][2];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int n = 0; n < 8; n++) begin
        for (int t = 0; t < 2; t++) begin
          logic [47:0] dm;
          dm = (t == 1) ? d_shear_i : (diag_q[n] ? d_diag_i : d_offdiag_i);
          pp0_q[n][t] <= 64'(p_q[n][t][31:0]) * 64'(dm[31:0]);
          pp1_q[n][t] <= 48'(p_q[n][t][31:0]) * 48'(dm[47:32]);
          pp2_q[n][t] <= $signed(p_q[n][t][63:32]) * $signed({1'b0, dm[31:0]});
          pp3_q[n][t] <= $signed(p_q[n][t][63:32]) * $signed({1'b0, dm[47:32]});
        end
      end
    end
  end

  // stage g: terms
  logic signed [112:0] t_q [8][2];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int n = 0; n < 8; n++) begin
        for (int t = 0; t < 2; t++) begin
          t_q[n][t] <= $signed({49'b0, pp0_q[n][t]})
                     + $signed({33'b0, pp1_q[n][t], 32'b0})
                     + $signed({{16{pp2_q[n][t][64]}}, pp2_q[n][t], 32'b0})
                     + $signed({pp3_q[n][t], 64'b0});
        end
      end
    end
  end

  // stage h: numerator scaled by 2^16, kept to 128 bits
  logic [127:0] num_q [8];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int n = 0; n < 8; n++) begin
        logic signed [112:0] s;
        s = t_q[n][0] + t_q[n][1];
        num_q[n] <= {s[111:0], 16'b0};
      end
    end
  end

  // stage i: magnitude plus half the divisor
  logic [127:0] div_q [8];
  logic [7:0]   nneg_q;
  logic [63:0]  half;

  assign half = {1'b0, side_q[3].jm[63:1]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int n = 0; n < 8; n++) begin
        logic neg;
        neg = num_q[n][127];
        div_q[n]  <= (neg ? ~num_q[n] : num_q[n]) + {64'b0, neg ? half + 64'd1 : half};
        nneg_q[n] <= neg;
      end
    end
  end

  // sideband
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= geo_i.side;
      for (int k = 1; k < NSTG; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NSTG; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int k = 1; k < NSTG; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_comb begin
    for (int n = 0; n < 8; n++) begin
      dividend_o[n] = div_q[n];
    end
  end

  assign nneg_o  = nneg_q;
  assign side_o  = side_q[NSTG-1];
  assign valid_o = vld_q[NSTG-1];

endmodule

// File: rtl/qes_div.sv
module qes_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [7:0][127:0]       dividend_i,
  input  logic [7:0]              nneg_i,
  input  qes_pkg::side_t          side_i,
  output logic                    valid_o,
  output qes_pkg::out_t           res_o
);

  localparam int unsigned NS = qes_pkg::DIV_STEPS;
  localparam int unsigned NL = qes_pkg::LANES;

  // dividend shifts out the top while quotient bits shift in at the bottom
  logic [127:0]   nq_q  [NS][NL];
  logic [63:0]    rem_q [NS][NL];
  qes_pkg::side_t sd_q  [NS];
  logic [NL-1:0]  ng_q  [NS];
  logic           vld_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_step
    logic [127:0]   nq_in  [NL];
    logic [63:0]    rem_in [NL];
    qes_pkg::side_t sd_in;
    logic [NL-1:0]  ng_in;
    logic           vld_in;
    logic [63:0]    rs [NL];
    logic [NL-1:0]  ge;

    if (k == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < NL; l++) begin
          nq_in[l]  = dividend_i[l];
          rem_in[l] = '0;
        end
      end
      assign sd_in  = side_i;
      assign ng_in  = nneg_i;
      assign vld_in = valid_i;
    end else begin : g_next
      always_comb begin
        for (int l = 0; l < NL; l++) begin
          nq_in[l]  = nq_q[k-1][l];
          rem_in[l] = rem_q[k-1][l];
        end
      end
      assign sd_in  = sd_q[k-1];
      assign ng_in  = ng_q[k-1];
      assign vld_in = vld_q[k-1];
    end

    // remainder is 64 bits wide; its top bit falls off on the shift
    always_comb begin
      for (int l = 0; l < NL; l++) begin
        rs[l] = {rem_in[l][62:0], nq_in[l][127]};
        ge[l] = (rs[l] >= sd_in.jm);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int l = 0; l < NL; l++) begin
          nq_q[k][l]  <= {nq_in[l][126:0], ge[l]};
          rem_q[k][l] <= ge[l] ? rs[l] - sd_in.jm : rs[l];
        end
        sd_q[k] <= sd_in;
        ng_q[k] <= ng_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end
  end

  // sign and saturation
  logic [63:0]    kv [NL];
  qes_pkg::side_t sd_last;

  assign sd_last = sd_q[NS-1];

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      logic [127:0] q;
      logic         neg;
      q   = nq_q[NS-1][l];
      neg = ng_q[NS-1][l] != sd_last.jneg;
      if (sd_last.sing) begin
        kv[l] = '0;
      end else if (!neg) begin
        kv[l] = (q[127:64] != '0 || q[63]) ? {1'b0, {63{1'b1}}} : q[63:0];
      end else begin
        kv[l] = (q[127:64] != '0 || (q[63] && q[62:0] != '0)) ? {1'b1, 63'b0}
                                                            : -q[63:0];
      end
    end
  end

  always_comb begin
    res_o.k_col0     = kv[0];
    res_o.k_col1     = kv[1];
    res_o.k_col2     = kv[2];
    res_o.k_col3     = kv[3];
    res_o.k_col4     = kv[4];
    res_o.k_col5     = kv[5];
    res_o.k_col6     = kv[6];
    res_o.k_col7     = kv[7];
    res_o.x_at_point = sd_last.xl;
    res_o.y_at_point = sd_last.yl;
    res_o.singular   = sd_last.sing;
    res_o.last       = sd_last.last;
  end

  assign valid_o = vld_q[NS-1];

endmodule

// File: rtl/quad_element_stiffness_at_gauss_point_core.sv
// Q4 element stiffness at one 2x2 Gauss point, plane stress. Each input beat carries four
// node coordinates (Q16.16) and a point index; the block returns eight row beats of
// det(J) * B^T D B in Q48.16, saturated, with the mapped point location, a singular flag
// (zero determinant, entries zero) and last on the eighth row. Rows leave one per cycle
// while the output is not stalled, and a new item is taken while the eighth row of the
// previous one issues. The first row beat of an item passes through the row sequencer,
// four geometry stages, five numerator stages, the 128-step division pipeline and the
// output register. Load d_diag, d_offdiag and d_shear only while the block is empty; the
// whole pipeline holds while a finished beat waits at the output.
module quad_element_stiffness_at_gauss_point_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  qes_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output qes_pkg::out_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [47:0]   cfg_data_i
);

  // material registers, written by software
  logic [47:0] d_diag_q, d_offdiag_q, d_shear_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_diag_q    <= '0;
      d_offdiag_q <= '0;
      d_shear_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        qes_pkg::CFG_D_DIAG:    d_diag_q    <= cfg_data_i;
        qes_pkg::CFG_D_OFFDIAG: d_offdiag_q <= cfg_data_i;
        qes_pkg::CFG_D_SHEAR:   d_shear_q   <= cfg_data_i;
        default: ;  // index three is ignored
      endcase
    end
  end

  // pipeline moves whenever the output register is free or being drained
  logic pipe_en;
  logic out_valid_q;
  qes_pkg::out_t out_q;

  assign pipe_en = !out_valid_q || !out_stall_i;

  // row sequencer: holds the item and issues rows 0..7
  logic          busy_q;
  logic [2:0]    row_q;
  qes_pkg::in_t  item_q;
  logic          take;

  assign take       = pipe_en && (!busy_q || row_q == 3'd7);
  assign in_stall_o = !take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      row_q  <= '0;
    end else if (pipe_en) begin
      row_q <= busy_q ? row_q + 3'd1 : 3'd0;
      if (take) begin
        busy_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && take) begin
      item_q <= in_data_i;
    end
  end

  // geometry: derivatives, jacobian, strain terms, location
  logic          geo_valid;
  qes_pkg::geo_t geo;

  qes_geom u_geom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (busy_q),
    .item_i  (item_q),
    .row_i   (row_q),
    .valid_o (geo_valid),
    .geo_o   (geo)
  );

  // numerators of one row, eight columns in parallel
  logic                 num_valid;
  logic [7:0][127:0]    dividend;
  logic [7:0]           nneg;
  qes_pkg::side_t       side;

  qes_numer u_numer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (pipe_en),
    .valid_i     (geo_valid),
    .geo_i       (geo),
    .d_diag_i    (d_diag_q),
    .d_offdiag_i (d_offdiag_q),
    .d_shear_i   (d_shear_q),
    .valid_o     (num_valid),
    .dividend_o  (dividend),
    .nneg_o      (nneg),
    .side_o      (side)
  );

  // division by |det J|, one quotient bit per stage, then sign and saturation
  logic          div_valid;
  qes_pkg::out_t div_res;

  qes_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (pipe_en),
    .valid_i    (num_valid),
    .dividend_i (dividend),
    .nneg_i     (nneg),
    .side_i     (side),
    .valid_o    (div_valid),
    .res_o      (div_res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en && div_valid) begin
      out_q <= div_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
